// ===== hw/rtl/oaids_pkg.sv =====
`default_nettype none
package oaids_pkg;

  localparam int DEPTH      = 256;
  localparam int VALUE_BITS = 32;

  localparam int REQ_W   = 3;
  localparam int ITEM_W  = 32;
  localparam int POS_W   = 9;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  // position/count compares are done at this width
  localparam int WIDE_W = 16;

  // first-match encoder: groups of GRP_SIZE cells
  localparam int GRP_SIZE = 16;
  localparam int GSEL_W   = $clog2(GRP_SIZE);
  localparam int NGRP     = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_PREPEND   = 3'd1,
    REQ_INSERT    = 3'd2,
    REQ_DEL_VALUE = 3'd3,
    REQ_SEARCH    = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_DEL_FIRST = 3'd6,
    REQ_DEL_LAST  = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_ENC1,
    S_ENC2,
    S_EXEC
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [CNT_W-1:0]      at;
    logic [VALUE_BITS-1:0] value;
    logic [CNT_W-1:0]      count;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/oaids_ifs.sv =====
`default_nettype none
interface oaids_in_if;
  import oaids_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [ITEM_W-1:0] item_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output req_type, output item_value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input item_value, input position,
                  output ready);
endinterface

interface oaids_out_if;
  import oaids_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [FOUND_W-1:0] found_index;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, output status, output found_index, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_index, input entry_count,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/oaids_cell.sv =====
`default_nettype none
module oaids_cell (
  input  wire logic                            clk,
  input  wire logic [oaids_pkg::CNT_W-1:0]     cell_idx,
  input  wire oaids_pkg::cell_ctrl_t           ctrl,
  input  wire logic [oaids_pkg::VALUE_BITS-1:0] lower_val,
  input  wire logic [oaids_pkg::VALUE_BITS-1:0] upper_val,
  output logic [oaids_pkg::VALUE_BITS-1:0]      val,
  output logic                                 match
);
  import oaids_pkg::*;

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;
  logic                  match_r;

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.op)
      OP_INS: begin
        if (cell_idx == ctrl.at) begin
          val_nxt = ctrl.value;
        end else if (cell_idx > ctrl.at) begin
          val_nxt = lower_val;
        end
      end
      OP_DEL: begin
        if (cell_idx >= ctrl.at) begin
          val_nxt = upper_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    match_r <= (val_r == ctrl.value) && (cell_idx < ctrl.count);
  end

  assign val   = val_r;
  assign match = match_r;
endmodule
`default_nettype wire

// ===== hw/rtl/oaids_enc.sv =====
`default_nettype none
module oaids_enc (
  input  wire logic                         clk,
  input  wire logic [oaids_pkg::DEPTH-1:0]  match,
  output logic                              found,
  output logic [oaids_pkg::IDX_W-1:0]       idx
);
  import oaids_pkg::*;

  logic [NGRP*GRP_SIZE-1:0] match_pad;
  logic [NGRP-1:0]          grp_any_nxt;
  logic [NGRP-1:0]          grp_any_r;
  logic [GSEL_W-1:0]        grp_low_nxt [NGRP];
  logic [GSEL_W-1:0]        grp_low_r   [NGRP];
  logic [GRP_W-1:0]         grp_sel;
  logic                     found_r;
  logic [IDX_W-1:0]         idx_r;

  assign match_pad = (NGRP*GRP_SIZE)'(match);

  // level 1: lowest set bit inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |match_pad[g*GRP_SIZE +: GRP_SIZE];
      grp_low_nxt[g] = '0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (match_pad[g*GRP_SIZE + b]) begin
          grp_low_nxt[g] = GSEL_W'(b);
        end
      end
    end
  end

  // level 2: lowest group with a hit
  always_comb begin
    grp_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        grp_sel = GRP_W'(g);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_low_r <= grp_low_nxt;
    found_r   <= |grp_any_r;
    idx_r     <= IDX_W'({grp_sel, grp_low_r[grp_sel]});
  end

  assign found = found_r;
  assign idx   = idx_r;
endmodule
`default_nettype wire

// ===== hw/rtl/ordered_array_insert_delete_search.sv =====
`default_nettype none
// Channel  Dir  Payload                                  Handshake
// in_ch    in   req_type[2:0] item_value[31:0] position[8:0]  valid/ready
// out_ch   out  status[2:0] found_index[7:0] entry_count[8:0] valid/ready
//
// One item at a time. Inserts, deletes by position/first/last and requests
// that fail on count go from accept straight to the shift of the cell row.
// Search and delete by value go through accept, compare in every cell, two
// levels of first-match encode, then shift or result. Synchronous active-low reset
// clears the count and control; cell contents are undefined until written.
// The final cycle waits while the output register holds an untaken item.
module ordered_array_insert_delete_search (
  input  wire logic  clk,
  input  wire logic  rst_n,
  oaids_in_if.sink   in_ch,
  oaids_out_if.source out_ch
);
  import oaids_pkg::*;

  state_t                state_r, state_nxt;
  req_t                  req_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [POS_W-1:0]      pos_r;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  out_valid_r;
  status_t               out_status_r, status_nxt;
  logic [FOUND_W-1:0]    out_found_r, found_nxt;
  logic [CNT_W-1:0]      out_count_r;

  cell_op_t              op_nxt;
  logic [CNT_W-1:0]      at_nxt;
  logic [CNT_W-1:0]      ins_at;
  cell_ctrl_t            ctrl;

  logic [VALUE_BITS-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic                  enc_found;
  logic [IDX_W-1:0]      enc_idx;

  logic                  accept;
  logic                  exec_fire;
  logic                  full;
  logic                  empty;

  assign accept    = in_ch.valid && in_ch.ready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          if (((req_t'(in_ch.req_type) == REQ_DEL_VALUE) ||
               (req_t'(in_ch.req_type) == REQ_SEARCH)) && !empty) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_CMP:  state_nxt = S_ENC1;
      S_ENC1: state_nxt = S_ENC2;
      S_ENC2: state_nxt = S_EXEC;
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // request decode for the shift cycle
  always_comb begin
    status_nxt = ST_OK;
    found_nxt  = '0;
    op_nxt     = OP_HOLD;
    at_nxt     = '0;
    count_nxt  = count_r;
    unique case (req_r)
      REQ_APPEND:  ins_at = count_r;
      REQ_PREPEND: ins_at = '0;
      default:     ins_at = CNT_W'(pos_r);
    endcase
    if ((req_r == REQ_APPEND) || (req_r == REQ_PREPEND) || (req_r == REQ_INSERT)) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else if (WIDE_W'(((req_r == REQ_INSERT) ? pos_r : POS_W'(ins_at))) >
                   WIDE_W'(count_r)) begin
        status_nxt = ST_BADPOS;
      end else begin
        op_nxt    = OP_INS;
        at_nxt    = ins_at;
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (empty) begin
      status_nxt = ST_EMPTY;
    end else begin
      unique case (req_r)
        REQ_DEL_VALUE: begin
          if (enc_found) begin
            op_nxt    = OP_DEL;
            at_nxt    = CNT_W'(enc_idx);
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        REQ_SEARCH: begin
          if (enc_found) begin
            found_nxt = FOUND_W'(enc_idx);
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        REQ_DEL_POS: begin
          if (WIDE_W'(pos_r) >= WIDE_W'(count_r)) begin
            status_nxt = ST_BADPOS;
          end else begin
            op_nxt    = OP_DEL;
            at_nxt    = CNT_W'(pos_r);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        REQ_DEL_FIRST: begin
          op_nxt    = OP_DEL;
          at_nxt    = '0;
          count_nxt = count_r - CNT_W'(1);
        end
        default: begin
          count_nxt = count_r - CNT_W'(1);
        end
      endcase
    end
  end

  always_comb begin
    ctrl.op    = exec_fire ? op_nxt : OP_HOLD;
    ctrl.at    = at_nxt;
    ctrl.value = val_r;
    ctrl.count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_t'(in_ch.req_type);
      val_r <= VALUE_BITS'(in_ch.item_value);
      pos_r <= in_ch.position;
    end
    if (exec_fire) begin
      out_status_r <= status_nxt;
      out_found_r  <= found_nxt;
      out_count_r  <= count_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    oaids_cell u_cell (
      .clk       (clk),
      .cell_idx  (CNT_W'(i)),
      .ctrl      (ctrl),
      .lower_val ((i == 0) ? val_r : cell_val[(i == 0) ? 0 : i - 1]),
      .upper_val ((i == DEPTH - 1) ? val_r : cell_val[(i == DEPTH - 1) ? i : i + 1]),
      .val       (cell_val[i]),
      .match     (cell_match[i])
    );
  end

  oaids_enc u_enc (
    .clk   (clk),
    .match (cell_match),
    .found (enc_found),
    .idx   (enc_idx)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.entry_count = out_count_r;
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import oaids_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct {
    int                 seq;
    status_t            status;
    logic [FOUND_W-1:0] found;
    logic [CNT_W-1:0]   count;
  } list_result_t;

  logic clk;
  logic rst_n;

  oaids_in_if  in_ch ();
  oaids_out_if out_ch ();

  ordered_array_insert_delete_search DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow copy of the list
  logic [VALUE_BITS-1:0] list_mem [DEPTH];
  int                    list_len;

  list_result_t owed_results [$];
  int           sent;
  int           errors;
  int           idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic list_result_t apply_request(input req_t op, input logic [31:0] v,
                                                 input logic [8:0] pos);
    list_result_t r;
    int at;
    int hit;
    int gap;
    int i;
    r.seq    = sent;
    r.status = ST_OK;
    r.found  = '0;
    if (op == REQ_APPEND || op == REQ_PREPEND || op == REQ_INSERT) begin
      at = (op == REQ_APPEND) ? list_len : (op == REQ_PREPEND) ? 0 : int'(pos);
      if (list_len >= DEPTH) begin
        r.status = ST_FULL;
      end else if (at > list_len) begin
        r.status = ST_BADPOS;
      end else begin
        for (i = list_len; i > at; i--) list_mem[i] = list_mem[i-1];
        list_mem[at] = v;
        list_len++;
      end
    end else if (list_len == 0) begin
      r.status = ST_EMPTY;
    end else begin
      hit = -1;
      for (i = list_len - 1; i >= 0; i--) if (list_mem[i] == v) hit = i;
      gap = -1;
      case (op)
        REQ_DEL_VALUE: begin
          if (hit < 0) r.status = ST_NOTFOUND;
          else gap = hit;
        end
        REQ_SEARCH: begin
          if (hit < 0) r.status = ST_NOTFOUND;
          else r.found = FOUND_W'(hit);
        end
        REQ_DEL_POS: begin
          if (int'(pos) >= list_len) r.status = ST_BADPOS;
          else gap = int'(pos);
        end
        REQ_DEL_FIRST: gap = 0;
        default: gap = list_len - 1;
      endcase
      if (gap >= 0) begin
        for (i = gap; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
        list_len--;
      end
    end
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  task automatic send_request(input req_t op, input logic [31:0] v, input logic [8:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= op;
    in_ch.item_value <= v;
    in_ch.position   <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    owed_results.push_back(apply_request(op, v, pos));
    sent++;
  endtask

  function automatic logic [31:0] fresh_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3, 4: return 32'($urandom_range(16)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed requests; values often taken from the list so they hit
  task automatic pick_request(input int ins_pct, output req_t op, output logic [31:0] v,
                              output logic [8:0] pos);
    if ($urandom_range(99) < 8) begin
      op  = req_t'($urandom_range(7));
      v   = $urandom;
      pos = 9'($urandom_range(511));
    end else if ($urandom_range(99) < ins_pct) begin
      op  = req_t'($urandom_range(2));
      v   = fresh_value();
      pos = 9'($urandom_range(list_len));
    end else begin
      op  = req_t'($urandom_range(7, 3));
      v   = (list_len > 0 && $urandom_range(3) != 0) ? list_mem[$urandom_range(list_len - 1)]
                                                     : fresh_value();
      pos = 9'($urandom_range(list_len));
    end
  endtask

  task automatic test_empty_and_edges();
    send_request(REQ_SEARCH,    32'd0, 9'd0);
    send_request(REQ_DEL_VALUE, 32'd0, 9'd0);
    send_request(REQ_DEL_POS,   32'd0, 9'd0);
    send_request(REQ_DEL_FIRST, 32'd0, 9'd0);
    send_request(REQ_DEL_LAST,  32'd0, 9'd0);
    send_request(REQ_INSERT,    32'd3, 9'd1);
    send_request(REQ_INSERT,    32'd3, 9'd511);
    send_request(REQ_APPEND,    32'h7fff_ffff, 9'd0);
    send_request(REQ_PREPEND,   32'h8000_0000, 9'd0);
    send_request(REQ_INSERT,    32'hffff_ffff, 9'd2);
    send_request(REQ_INSERT,    32'd0, 9'd1);
    send_request(REQ_SEARCH,    32'hffff_ffff, 9'd0);
    send_request(REQ_SEARCH,    32'd12345, 9'd0);
    send_request(REQ_APPEND,    32'd5, 9'd0);
    send_request(REQ_INSERT,    32'd5, 9'd0);
    send_request(REQ_SEARCH,    32'd5, 9'd0);
    send_request(REQ_DEL_VALUE, 32'd5, 9'd0);
    send_request(REQ_SEARCH,    32'd5, 9'd0);
    send_request(REQ_DEL_VALUE, 32'd77, 9'd0);
    send_request(REQ_DEL_POS,   32'd0, 9'd5);
    send_request(REQ_DEL_POS,   32'd0, 9'd256);
    send_request(REQ_DEL_POS,   32'd0, 9'd1);
    send_request(REQ_DEL_FIRST, 32'd0, 9'd0);
    send_request(REQ_DEL_LAST,  32'd0, 9'd0);
  endtask

  task automatic test_fill_to_full();
    req_t        op;
    logic [31:0] v;
    logic [8:0]  pos;
    while (list_len < DEPTH) begin
      idle_pct = (list_len < 100) ? 0 : 10;
      pick_request(95, op, v, pos);
      send_request(op, v, pos);
    end
    idle_pct = 10;
  endtask

  task automatic test_full_list();
    logic [31:0] marker;
    bit          dup;
    int          i;
    send_request(REQ_APPEND,  32'd1, 9'd0);
    send_request(REQ_PREPEND, 32'd1, 9'd0);
    send_request(REQ_INSERT,  32'd1, 9'd256);
    send_request(REQ_SEARCH,  list_mem[0], 9'd0);
    send_request(REQ_DEL_LAST, 32'd0, 9'd0);
    do begin
      marker = $urandom;
      dup    = 1'b0;
      for (i = 0; i < list_len; i++) if (list_mem[i] == marker) dup = 1'b1;
    end while (dup);
    send_request(REQ_APPEND,    marker, 9'd0);
    send_request(REQ_SEARCH,    marker, 9'd0);
    send_request(REQ_DEL_VALUE, marker, 9'd0);
    send_request(REQ_INSERT,    marker, 9'd255);
    send_request(REQ_DEL_POS,   32'd0, 9'd256);
    send_request(REQ_DEL_POS,   32'd0, 9'd255);
    send_request(REQ_INSERT,    marker, 9'd256);
    send_request(REQ_INSERT,    marker, 9'd255);
  endtask

  task automatic test_random_mix();
    req_t        op;
    logic [31:0] v;
    logic [8:0]  pos;
    int          n;
    for (n = 0; n < 130; n++) begin
      pick_request((n < 60) ? 50 : 25, op, v, pos);
      send_request(op, v, pos);
    end
  endtask

  // result side: random backpressure and in-order compare
  initial begin
    list_result_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result item with nothing pending");
        end else begin
          want = owed_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("item %0d status %0d, want %0d",
                                      want.seq, out_ch.status, want.status));
          if (out_ch.found_index !== want.found)
            report_mismatch($sformatf("item %0d found_index %0d, want %0d",
                                      want.seq, out_ch.found_index, want.found));
          if (out_ch.entry_count !== want.count)
            report_mismatch($sformatf("item %0d entry_count %0d, want %0d",
                                      want.seq, out_ch.entry_count, want.count));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck = 0;
      else stuck++;
    end
    $display("ordered_array_insert_delete_search: mismatch");
    $finish;
  end

  initial begin
    errors   = 0;
    sent     = 0;
    list_len = 0;
    idle_pct = 10;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_APPEND;
    in_ch.item_value <= '0;
    in_ch.position   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_edges();
    test_fill_to_full();
    test_full_list();
    test_random_mix();

    in_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("ordered_array_insert_delete_search: match");
    end else begin
      $display("ordered_array_insert_delete_search: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/oaids_pkg.sv
hw/rtl/oaids_ifs.sv
hw/rtl/oaids_cell.sv
hw/rtl/oaids_enc.sv
hw/rtl/ordered_array_insert_delete_search.sv
tb/tb_top.sv
